// File: hw/rtl/assert_macros.svh
// assertion macros shared by the squares generator rtl
// expects clock and reset to be in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is high
`define SQRNG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies property in the next
`define SQRNG_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// File: hw/rtl/sqrng_pkg.sv
// types, constants and microcode table of the squares generator
// no dependencies; used by sqrng_seq, sqrng_dp and squares_counter_rng_core
package sqrng_pkg;

   localparam logic [63:0] SQ_KEY    = 64'hc8e4fd154ce32f6d;
   localparam int unsigned PC_W      = 5;
   localparam int unsigned DIVR_W    = 33;
   localparam int unsigned REM_W     = 32;
   localparam int unsigned DIV_STEPS = 64;
   localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [1:0] {
      CSR_RAY_INDEX,
      CSR_RAY_COUNT,
      CSR_SEED_FRACTION
   } csr_reg_type;

   typedef enum logic [2:0] {
      MUL_C_LL,
      MUL_C_LH,
      MUL_C_HL,
      MUL_V_LL,
      MUL_V_LH,
      MUL_S_LL,
      MUL_S_LH
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SH32,
      ACC_SH33
   } acc_op_type;

   typedef enum logic [1:0] {
      ADD_ZERO,
      ADD_A,
      ADD_B,
      ADD_SEED
   } add_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_AB,
      WR_V,
      WR_VK,
      WR_WORD,
      WR_CNT
   } wr_op_type;

   typedef enum logic [1:0] {
      DIV_NONE,
      DIV_LOAD_WORD,
      DIV_LOAD_SHARE,
      DIV_STEP
   } div_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP_DIV,
      SEQ_DONE_ITEM,
      SEQ_DONE_CFG
   } seq_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   typedef struct packed {
      mul_sel_type mul;
      acc_op_type  acc;
      add_sel_type add;
      wr_op_type   wr;
      div_op_type  div;
      seq_op_type  seq;
   } ucode_type;

   typedef struct packed {
      mul_sel_type mul;
      acc_op_type  acc;
      add_sel_type add;
      wr_op_type   wr;
      div_op_type  div;
      logic        result_load;
   } ctrl_type;

   localparam pc_type PC_ITEM   = pc_type'(0);
   localparam pc_type PC_RELOAD = pc_type'(22);
   localparam pc_type PC_LAST   = pc_type'(26);

   // microcode: item program from PC_ITEM, counter reload from PC_RELOAD
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      w = '{mul: MUL_C_LL, acc: ACC_HOLD, add: ADD_ZERO, wr: WR_NONE,
            div: DIV_NONE, seq: SEQ_NEXT};
      case (pc)
         // a = counter * key
         5'd0:  w.mul = MUL_C_LL;
         5'd1:  begin w.mul = MUL_C_LH; w.acc = ACC_LOAD; end
         5'd2:  begin w.mul = MUL_C_HL; w.acc = ACC_SH32; end
         5'd3:  w.acc = ACC_SH32;
         5'd4:  w.wr = WR_AB;
         // round one
         5'd5:  w.mul = MUL_V_LL;
         5'd6:  begin w.mul = MUL_V_LH; w.acc = ACC_LOAD; w.add = ADD_A; end
         5'd7:  begin w.acc = ACC_SH33; w.wr = WR_V; end
         // round two
         5'd8:  w.mul = MUL_V_LL;
         5'd9:  begin w.mul = MUL_V_LH; w.acc = ACC_LOAD; w.add = ADD_B; end
         5'd10: begin w.acc = ACC_SH33; w.wr = WR_V; end
         // round three
         5'd11: w.mul = MUL_V_LL;
         5'd12: begin w.mul = MUL_V_LH; w.acc = ACC_LOAD; w.add = ADD_A; end
         5'd13: begin w.acc = ACC_SH33; w.wr = WR_V; end
         // round four keeps the unswapped sum
         5'd14: w.mul = MUL_V_LL;
         5'd15: begin w.mul = MUL_V_LH; w.acc = ACC_LOAD; w.add = ADD_B; end
         5'd16: begin w.acc = ACC_SH33; w.wr = WR_VK; end
         // round five folds into the word and starts the range divide
         5'd17: w.mul = MUL_V_LL;
         5'd18: begin w.mul = MUL_V_LH; w.acc = ACC_LOAD; w.add = ADD_A; end
         5'd19: begin w.acc = ACC_SH33; w.wr = WR_WORD; w.div = DIV_LOAD_WORD; end
         5'd20: begin w.div = DIV_STEP; w.seq = SEQ_LOOP_DIV; end
         5'd21: w.seq = SEQ_DONE_ITEM;
         // reload: share = all ones / streams, counter = index * share + seed
         5'd22: w.div = DIV_LOAD_SHARE;
         5'd23: begin w.div = DIV_STEP; w.seq = SEQ_LOOP_DIV; end
         5'd24: w.mul = MUL_S_LL;
         5'd25: begin w.mul = MUL_S_LH; w.acc = ACC_LOAD; w.add = ADD_SEED; end
         5'd26: begin w.acc = ACC_SH32; w.wr = WR_CNT; w.seq = SEQ_DONE_CFG; end
         default: w.seq = SEQ_DONE_CFG;
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/sqrng_seq.sv
// microcode sequencer of the squares generator: step counter, table, jumps
// depends on sqrng_pkg and assert_macros.svh
`include "assert_macros.svh"

module sqrng_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start_item,
   input  logic                start_cfg,
   input  logic                div_last,
   input  logic                out_free,
   output sqrng_pkg::ctrl_type ctrl,
   output logic                idle
);
   import sqrng_pkg::*;

   seq_state_type state_ff, state_in;
   pc_type        pc_ff, pc_in;
   ucode_type     uw;

   assign uw = ucode_rom(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= PC_ITEM;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   // next state and step
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_cfg) begin
               state_in = ST_RUN;
               pc_in    = PC_RELOAD;
            end else if (start_item) begin
               state_in = ST_RUN;
               pc_in    = PC_ITEM;
            end
         end
         ST_RUN: begin
            if (start_cfg) begin
               pc_in = PC_RELOAD;
            end else begin
               unique case (uw.seq)
                  SEQ_NEXT:      pc_in = pc_ff + pc_type'(1);
                  // branch back to self until the last divide step
                  SEQ_LOOP_DIV:  if (div_last) pc_in = pc_ff + pc_type'(1);
                  SEQ_DONE_ITEM: if (out_free) state_in = ST_IDLE;
                  SEQ_DONE_CFG:  state_in = ST_IDLE;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      ctrl = '{mul: uw.mul, acc: ACC_HOLD, add: uw.add, wr: WR_NONE,
               div: DIV_NONE, result_load: 1'b0};
      idle = 1'b1;
      unique case (state_ff)
         ST_IDLE: idle = 1'b1;
         ST_RUN: begin
            idle             = 1'b0;
            ctrl.acc         = uw.acc;
            ctrl.wr          = uw.wr;
            ctrl.div         = uw.div;
            ctrl.result_load = (uw.seq == SEQ_DONE_ITEM) && out_free;
         end
         default: idle = 1'b1;
      endcase
   end

   `SQRNG_ASSERT(a_pc_in_program, (state_ff == ST_RUN) |-> (pc_ff <= PC_LAST), "step counter left the program")
   `SQRNG_ASSERT_NEXT(a_idle_after_result, ctrl.result_load && !start_cfg, state_ff == ST_IDLE, "sequencer busy after result")
   `SQRNG_ASSERT(a_idle_frozen, idle |-> (ctrl.wr == WR_NONE && ctrl.div == DIV_NONE), "datapath written while idle")

endmodule

// File: hw/rtl/sqrng_dp.sv
// datapath of the squares generator: shared 32x32 multiplier, 64-bit
// accumulator, round registers, counter and a one-bit-per-step divider
// depends on sqrng_pkg
module sqrng_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  sqrng_pkg::ctrl_type             ctrl,
   input  logic [sqrng_pkg::DIVR_W-1:0]    span,
   input  logic [sqrng_pkg::DIVR_W-1:0]    stream_dvs,
   input  logic [30:0]                     ray_index,
   input  logic [63:0]                     seed,
   output logic [63:0]                     word,
   output logic [sqrng_pkg::REM_W-1:0]     remainder,
   output logic                            div_last
);
   import sqrng_pkg::*;

   logic [63:0]       cnt_ff, cnt_in;
   logic [63:0]       a_ff, a_in, b_ff, b_in, v_ff, v_in;
   logic [63:0]       keep_ff, keep_in, word_ff, word_in;
   logic [63:0]       acc_ff, acc_in, prod_ff, prod_in;
   logic [63:0]       quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [31:0]       mul_x, mul_y;
   logic [63:0]       addend, swapped, fold;
   logic [DIVR_W-1:0] rem_shift;
   logic [DIVR_W:0]   diff;
   logic              fits;

   // operand selection for the shared multiplier
   always_comb begin
      case (ctrl.mul)
         MUL_C_LL: begin mul_x = cnt_ff[31:0];      mul_y = SQ_KEY[31:0];   end
         MUL_C_LH: begin mul_x = cnt_ff[31:0];      mul_y = SQ_KEY[63:32];  end
         MUL_C_HL: begin mul_x = cnt_ff[63:32];     mul_y = SQ_KEY[31:0];   end
         MUL_V_LL: begin mul_x = v_ff[31:0];        mul_y = v_ff[31:0];     end
         MUL_V_LH: begin mul_x = v_ff[31:0];        mul_y = v_ff[63:32];    end
         MUL_S_LL: begin mul_x = {1'b0, ray_index}; mul_y = quo_ff[31:0];   end
         MUL_S_LH: begin mul_x = {1'b0, ray_index}; mul_y = quo_ff[63:32];  end
         default:  begin mul_x = '0;                mul_y = '0;             end
      endcase
      prod_in = mul_x * mul_y;
   end

   // accumulator: products of a square split into halves, mod 2^64
   always_comb begin
      case (ctrl.add)
         ADD_ZERO: addend = '0;
         ADD_A:    addend = a_ff;
         ADD_B:    addend = b_ff;
         ADD_SEED: addend = seed;
         default:  addend = '0;
      endcase
      case (ctrl.acc)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ff + addend;
         ACC_SH32: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         // cross term appears twice in a square
         ACC_SH33: acc_in = acc_ff + {prod_ff[30:0], 33'd0};
         default:  acc_in = acc_ff;
      endcase
      swapped = {acc_in[31:0], acc_in[63:32]};
      fold    = keep_ff ^ {32'd0, acc_in[63:32]};
   end

   // round registers and counter
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      v_in    = v_ff;
      keep_in = keep_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      case (ctrl.wr)
         WR_AB: begin
            a_in   = acc_in;
            b_in   = acc_in + SQ_KEY;
            v_in   = acc_in;
            cnt_in = cnt_ff + 64'd1;
         end
         WR_V:    v_in = swapped;
         WR_VK: begin
            keep_in = acc_in;
            v_in    = swapped;
         end
         WR_WORD: word_in = fold;
         WR_CNT:  cnt_in  = acc_in;
         default: ;
      endcase
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[63]};
      diff      = {1'b0, rem_shift} - {1'b0, dvs_ff};
      fits      = !diff[DIVR_W];
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      dcnt_in   = dcnt_ff;
      case (ctrl.div)
         DIV_LOAD_WORD: begin
            quo_in  = fold;
            rem_in  = '0;
            dvs_in  = span;
            dcnt_in = '0;
         end
         DIV_LOAD_SHARE: begin
            quo_in  = '1;
            rem_in  = '0;
            dvs_in  = stream_dvs;
            dcnt_in = '0;
         end
         DIV_STEP: begin
            quo_in  = {quo_ff[62:0], fits};
            rem_in  = fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            dcnt_in = dcnt_ff + DCNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      v_ff    <= v_in;
      keep_ff <= keep_in;
      word_ff <= word_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         dcnt_ff <= dcnt_in;
      end
   end

   assign word      = word_ff;
   assign remainder = rem_ff;
   assign div_last  = (dcnt_ff == DCNT_W'(DIV_STEPS - 1));

endmodule

// File: hw/rtl/squares_counter_rng_core.sv
// Counter-based squares random generator, 64-bit word, five rounds.
// Request channel (req_*): one beat carries an inclusive range low..high.
// Response channel (rsp_*): one beat per request with the raw 64-bit word,
// low + word mod (high - low + 1), and an error flag with value = low when
// high is below low. Each request uses the counter and then advances it.
// Each request runs the single 32x32 multiplier through counter * key and the
// five squaring rounds, then a 64-step restoring divider reduces the word; a
// new request is taken only once the previous result has been loaded.
// Configuration (csr_*): a write to ray_index, ray_count or seed_fraction
// recomputes the start counter index * floor((2^64-1)/count) + seed through
// the same divider and multiplier; req_ready stays low until the reload is
// done. A write to an unused index is dropped.
// Reset: registers return to index 0, count 1, seed 0 and the counter to 0;
// the block is ready in the cycle after reset.
// Stall: the result waits in the output register while the next request is
// already taken; that request then holds at its last step until the earlier
// beat leaves.
// Depends on sqrng_pkg, sqrng_seq, sqrng_dp and assert_macros.svh.
`include "assert_macros.svh"

module squares_counter_rng_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_random_word,
   output logic signed [31:0] rsp_ranged_value,
   output logic               rsp_range_error,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import sqrng_pkg::*;

   logic [30:0]        ray_index_ff, ray_count_ff;
   logic [63:0]        seed_ff;
   logic signed [31:0] lo_ff, hi_ff;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_word_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_err_ff;

   logic               req_acc, cfg_hit, seq_idle, out_free, div_last, range_err;
   logic [DIVR_W-1:0]  span, stream_dvs;
   logic [63:0]        word;
   logic [REM_W-1:0]   remainder;
   ctrl_type           ctrl;

   assign cfg_hit   = csr_wr_en && (csr_index == CSR_RAY_INDEX ||
                                    csr_index == CSR_RAY_COUNT ||
                                    csr_index == CSR_SEED_FRACTION);
   assign req_ready = seq_idle && !csr_wr_en;
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // span is 1 to 2^32 for a proper range
   assign span       = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff} + DIVR_W'(1);
   assign range_err  = hi_ff < lo_ff;
   assign stream_dvs = (ray_count_ff == '0) ? DIVR_W'(1) : {2'b00, ray_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_index_ff <= '0;
         ray_count_ff <= 31'd1;
         seed_ff      <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RAY_INDEX:     ray_index_ff <= csr_wdata[30:0];
            CSR_RAY_COUNT:     ray_count_ff <= csr_wdata[30:0];
            CSR_SEED_FRACTION: seed_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         lo_ff <= req_range_low;
         hi_ff <= req_range_high;
      end
   end

   sqrng_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start_item (req_acc),
      .start_cfg  (cfg_hit),
      .div_last   (div_last),
      .out_free   (out_free),
      .ctrl       (ctrl),
      .idle       (seq_idle)
   );

   sqrng_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .span       (span),
      .stream_dvs (stream_dvs),
      .ray_index  (ray_index_ff),
      .seed       (seed_ff),
      .word       (word),
      .remainder  (remainder),
      .div_last   (div_last)
   );

   // output register parts the response side from the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.result_load) begin
         rsp_word_ff  <= word;
         rsp_value_ff <= range_err ? lo_ff : lo_ff + $signed(remainder);
         rsp_err_ff   <= range_err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_word  = rsp_word_ff;
   assign rsp_ranged_value = rsp_value_ff;
   assign rsp_range_error  = rsp_err_ff;

   `SQRNG_ASSERT_NEXT(a_cfg_blocks_req, cfg_hit, !req_ready, "request taken during counter reload")
   `SQRNG_ASSERT_NEXT(a_no_instant_result, req_acc, !ctrl.result_load, "result loaded right after request")
   `SQRNG_ASSERT_NEXT(a_error_gives_low, ctrl.result_load, !rsp_err_ff || rsp_value_ff == lo_ff, "inverted range did not return low")

endmodule

// File: bench/squares_counter_rng_core_tb.sv
`timescale 1ns / 100ps
// self-checking bench for squares_counter_rng_core: range requests in, words out
// holds its own squares predictor and counter; needs sqrng_pkg and the core rtl

typedef struct packed {
   logic [63:0]        word;
   logic signed [31:0] ranged;
   logic               err;
} draw_type;

class rng_scoreboard;
   localparam logic [63:0] KEY = 64'hc8e4fd154ce32f6d;

   bit [30:0] stream_index;
   bit [30:0] stream_count;
   bit [63:0] seed;
   bit [63:0] counter;
   draw_type  pending_draws[$];
   int        mismatches;

   function new();
      stream_index = '0;
      stream_count = 31'd1;
      seed         = '0;
      mismatches   = 0;
      reload_counter();
   endfunction

   function bit [63:0] swap_halves(bit [63:0] v);
      return {v[31:0], v[63:32]};
   endfunction

   // five squaring rounds keyed by the counter
   function bit [63:0] squares_hash(bit [63:0] c);
      bit [63:0] a, b, v, keep;
      a = c * KEY;
      b = a + KEY;
      v = a;
      v = swap_halves(v * v + a);
      v = swap_halves(v * v + b);
      v = swap_halves(v * v + a);
      keep = v * v + b;
      v = swap_halves(keep);
      return keep ^ ((v * v + a) >> 32);
   endfunction

   function void reload_counter();
      bit [63:0] streams, share;
      streams = (stream_count == 0) ? 64'd1 : {33'd0, stream_count};
      share   = {64{1'b1}} / streams;
      counter = {33'd0, stream_index} * share + seed;
   endfunction

   function void write_register(logic [1:0] idx, logic [63:0] data);
      case (idx)
         sqrng_pkg::CSR_RAY_INDEX:     stream_index = data[30:0];
         sqrng_pkg::CSR_RAY_COUNT:     stream_count = data[30:0];
         sqrng_pkg::CSR_SEED_FRACTION: seed = data;
         default: return;
      endcase
      reload_counter();
   endfunction

   function void note_request(logic signed [31:0] lo, logic signed [31:0] hi);
      draw_type  d;
      bit [63:0] span, rem;
      longint    lo64, hi64;
      lo64 = lo;
      hi64 = hi;
      d.word = squares_hash(counter);
      counter = counter + 64'd1;
      if (hi64 < lo64) begin
         d.err    = 1'b1;
         d.ranged = lo;
      end else begin
         // span runs from 1 up to 2^32
         span     = 64'(hi64 - lo64 + 1);
         rem      = d.word % span;
         d.err    = 1'b0;
         d.ranged = lo + rem[31:0];
      end
      pending_draws.push_back(d);
   endfunction

   function void check_response(logic [63:0] word, logic signed [31:0] ranged, logic err);
      draw_type d;
      if (pending_draws.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response beat with nothing pending: word %h value %0d err %b",
                     $time, word, ranged, err);
         return;
      end
      d = pending_draws.pop_front();
      if (word !== d.word || ranged !== d.ranged || err !== d.err) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch word %h/%h value %0d/%0d err %b/%b (expected/actual)",
                     $time, d.word, word, d.ranged, ranged, d.err, err);
      end
   endfunction

   function int outstanding();
      return pending_draws.size();
   endfunction

   function bit failed();
      return mismatches != 0 || pending_draws.size() != 0;
   endfunction
endclass

module squares_counter_rng_core_tb;
   import sqrng_pkg::*;

   localparam logic [1:0]         CSR_UNUSED_INDEX = 2'd3;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
   localparam int                 IDLE_PCT    = 27;
   localparam int                 HOLD_CYCLES = 700;
   localparam int                 TAIL_CYCLES = 100;
   localparam int                 CYCLE_LIMIT = 1_000_000;
   localparam int                 N_CORNERS   = 18;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_range_low = '0;
   logic signed [31:0] req_range_high = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [63:0]        rsp_random_word;
   logic signed [31:0] rsp_ranged_value;
   logic               rsp_range_error;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   rng_scoreboard board;
   bit            no_gaps = 1'b0;
   int            hold_requests = 0;
   int            holds_served = 0;
   int            hold_left = 0;
   int            cycles = 0;

   // corner ranges: full width, single value, both ends, inverted
   logic signed [31:0] corner_lows [N_CORNERS] = '{
      INT_MIN, 0, INT_MIN, INT_MAX, 0, -1, INT_MIN, INT_MAX - 1, 5,
      INT_MAX, 0, -1, INT_MIN, 0, 1, -7, 100, 0};
   logic signed [31:0] corner_highs [N_CORNERS] = '{
      INT_MAX, 0, INT_MIN, INT_MAX, 1, 0, INT_MIN + 1, INT_MAX, 4,
      INT_MIN, -1, INT_MIN, -1, INT_MAX, 2, 9, 100 + 65535, 2};

   squares_counter_rng_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_word  (rsp_random_word),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_range_error  (rsp_range_error),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random back-pressure, plus long hold-offs on request
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (no_gaps) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_random_word, rsp_ranged_value, rsp_range_error);
   end

   // valid stays up into the next beat unless an idle cycle is drawn
   task automatic offer_range(logic signed [31:0] lo, logic signed [31:0] hi);
      req_valid      <= 1'b1;
      req_range_low  <= lo;
      req_range_high <= hi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(lo, hi);
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] data);
      wait_for_results();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_register(idx, data);
      csr_wr_en <= 1'b0;
      // counter reload runs through the divider; ready drops meanwhile
      @(posedge clock);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic offer_random(int n);
      longint l, h, t;
      int     k;
      repeat (n) begin
         l = $signed($urandom);
         case ($urandom_range(9))
            0, 1, 2: h = $signed($urandom);
            3: h = l;
            4: h = l + longint'($urandom_range(15));
            5: begin
               l = longint'(INT_MIN) + longint'($urandom_range(3));
               h = longint'(INT_MAX) - longint'($urandom_range(3));
            end
            6: begin
               k = $urandom_range(31);
               h = l + (longint'(1) << k) - 1;
            end
            7: h = l - 1 - longint'($urandom_range(200));
            default: begin
               h = $signed($urandom);
               if (h < l) begin
                  t = h;
                  h = l;
                  l = t;
               end
            end
         endcase
         if (h > longint'(INT_MAX)) h = INT_MAX;
         if (h < longint'(INT_MIN)) h = INT_MIN;
         offer_range(l[31:0], h[31:0]);
      end
   endtask

   initial begin
      logic [30:0] pick;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_CORNERS; i++)
         offer_range(corner_lows[i], corner_highs[i]);
      offer_random(140);
      wait_for_results();
      offer_random(60);

      // zero stream count acts as one; upper bits of the write are dropped
      write_csr(CSR_RAY_COUNT, {$urandom, 1'b1, 31'd0});
      write_csr(CSR_RAY_INDEX, {$urandom, 1'b0, 31'h7fff_ffff});
      offer_random(150);

      write_csr(CSR_RAY_COUNT, {33'd0, 31'h7fff_ffff});
      write_csr(CSR_RAY_INDEX, 64'd1);
      write_csr(CSR_SEED_FRACTION, {$urandom, $urandom});
      no_gaps = 1'b1;
      offer_random(200);
      no_gaps = 1'b0;

      // a dropped write must leave the running counter alone
      write_csr(CSR_UNUSED_INDEX, {$urandom, $urandom});
      offer_random(100);

      // counter wraps a few beats in, with the receiver stalled long
      write_csr(CSR_RAY_INDEX, 64'd0);
      write_csr(CSR_RAY_COUNT, 64'd1);
      write_csr(CSR_SEED_FRACTION, {64{1'b1}} - 64'd2);
      hold_requests++;
      offer_random(150);

      for (int p = 0; p < 5; p++) begin
         if (p == 0) begin
            write_csr(CSR_SEED_FRACTION, 64'd0);
         end else begin
            write_csr(CSR_SEED_FRACTION, {$urandom, $urandom});
         end
         pick = (p % 2) ? 31'($urandom_range(8)) : 31'($urandom);
         write_csr(CSR_RAY_COUNT, {$urandom, 1'b0, pick});
         write_csr(CSR_RAY_INDEX, {$urandom, $urandom});
         offer_random(130);
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.failed()) begin
         $display("[FAIL] regression broken");
      end else begin
         $display("[ OK ] regression clean");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sqrng_pkg.sv
hw/rtl/sqrng_seq.sv
hw/rtl/sqrng_dp.sv
hw/rtl/squares_counter_rng_core.sv
bench/squares_counter_rng_core_tb.sv
